// ----- hdl/pst_pkg.sv -----
// ----------------------------------------------------------------------------
// pst_pkg
// Shared widths, reset values and register map of the servo angle tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

  localparam int POS_BITS  = 10;
  localparam int FRAC_BITS = 16;

  localparam int GAIN_W  = 32;
  localparam int SUM_W   = 24;
  localparam int ANGLE_W = 16;
  localparam int ERR_W   = POS_BITS + 1;
  localparam int DERR_W  = POS_BITS + 2;

  localparam int PROD_P_W = GAIN_W + ERR_W;
  localparam int PROD_I_W = GAIN_W + SUM_W;
  localparam int PROD_D_W = GAIN_W + DERR_W;
  localparam int CORR_W   = PROD_I_W + 2;
  localparam int CORR_HI_W = CORR_W - FRAC_BITS;
  localparam int ACC_W    = CORR_HI_W + 1;

  localparam int IN_TDATA_W  = ((POS_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ANGLE_W + 7) / 8) * 8;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [IDX_W-1:0] REG_SETPOINT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ANGLE_MIN = 3'd4;
  localparam logic [IDX_W-1:0] REG_ANGLE_MAX = 3'd5;

  // 0.03 in the gain format, truncated
  localparam longint GAIN_P_RESET_INT = (3 * (longint'(1) << FRAC_BITS)) / 100;
  localparam logic signed [GAIN_W-1:0] GAIN_P_RESET = GAIN_W'(GAIN_P_RESET_INT);

  localparam logic [POS_BITS-1:0] SETPOINT_RESET = POS_BITS'(512);
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN_RESET = {1'b1, {(ANGLE_W-1){1'b0}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX_RESET = {1'b0, {(ANGLE_W-1){1'b1}}};

  localparam logic signed [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W-1){1'b0}}};

endpackage

`default_nettype wire

// ----- hdl/pid_servo_angle_tracker.sv -----
// ----------------------------------------------------------------------------
// pid_servo_angle_tracker
// One axis of a positional PID servo loop: error, saturating integral,
// Q16.16 gain products, truncation toward zero and angle clamp.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle unless m_tready holds the output, through four registered
//   stages: error and integral, gain products, correction sum, angle accumulate and clamp
// each stage has its own valid bit, so beats move into empty stages while a result waits
// reset (rst, synchronous) empties the pipeline, zeroes the integral, previous
//   error and angle, and loads the register defaults
`default_nettype none

module pid_servo_angle_tracker (
  input  wire                                clk,
  input  wire                                rst,
  // slave side, tdata: position [POS_BITS-1:0], zero padded
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [pst_pkg::IN_TDATA_W-1:0]     s_tdata,
  // master side, tdata: angle [15:0]
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [pst_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // configuration
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [pst_pkg::ADDR_W-1:0]         paddr,
  input  wire  [pst_pkg::DATA_W-1:0]         pwdata,
  output logic [pst_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  // configuration registers
  logic signed [pst_pkg::GAIN_W-1:0]  gain_p;
  logic signed [pst_pkg::GAIN_W-1:0]  gain_i;
  logic signed [pst_pkg::GAIN_W-1:0]  gain_d;
  logic        [pst_pkg::POS_BITS-1:0] setpoint;
  logic signed [pst_pkg::ANGLE_W-1:0] angle_min;
  logic signed [pst_pkg::ANGLE_W-1:0] angle_max;

  // loop state
  logic signed [pst_pkg::SUM_W-1:0]   error_sum;
  logic signed [pst_pkg::ERR_W-1:0]   previous_error;
  logic signed [pst_pkg::ANGLE_W-1:0] angle_now;

  // pipeline
  logic v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3;
  logic signed [pst_pkg::ERR_W-1:0]      err_r;
  logic signed [pst_pkg::SUM_W-1:0]      sum_r;
  logic signed [pst_pkg::DERR_W-1:0]     derr_r;
  logic signed [pst_pkg::PROD_P_W-1:0]   prod_p;
  logic signed [pst_pkg::PROD_I_W-1:0]   prod_i;
  logic signed [pst_pkg::PROD_D_W-1:0]   prod_d;
  logic signed [pst_pkg::CORR_HI_W-1:0]  corr_hi;
  logic                                  frac_nz;

  logic                                  cfg_wr;
  logic        [pst_pkg::IDX_W-1:0]      cfg_idx;
  logic        [pst_pkg::POS_BITS-1:0]   pos;
  logic signed [pst_pkg::ERR_W-1:0]      err_c;
  logic signed [pst_pkg::SUM_W:0]        sum_wide;
  logic signed [pst_pkg::SUM_W-1:0]      error_sum_next;
  logic signed [pst_pkg::DERR_W-1:0]     derr_c;
  logic signed [pst_pkg::CORR_W-1:0]     corr_c;
  logic signed [pst_pkg::ACC_W-1:0]      acc_c;
  logic signed [pst_pkg::ACC_W-1:0]      acc_trunc;
  logic signed [pst_pkg::ACC_W-1:0]      lim_min;
  logic signed [pst_pkg::ACC_W-1:0]      lim_max;
  logic signed [pst_pkg::ANGLE_W-1:0]    angle_now_next;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[pst_pkg::ADDR_W-1:2];

  always_comb begin
    case (cfg_idx)
      pst_pkg::REG_GAIN_P:    prdata = pst_pkg::DATA_W'(gain_p);
      pst_pkg::REG_GAIN_I:    prdata = pst_pkg::DATA_W'(gain_i);
      pst_pkg::REG_GAIN_D:    prdata = pst_pkg::DATA_W'(gain_d);
      pst_pkg::REG_SETPOINT:  prdata = pst_pkg::DATA_W'(setpoint);
      pst_pkg::REG_ANGLE_MIN: prdata = pst_pkg::DATA_W'(angle_min);
      pst_pkg::REG_ANGLE_MAX: prdata = pst_pkg::DATA_W'(angle_max);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p    <= pst_pkg::GAIN_P_RESET;
      gain_i    <= '0;
      gain_d    <= '0;
      setpoint  <= pst_pkg::SETPOINT_RESET;
      angle_min <= pst_pkg::ANGLE_MIN_RESET;
      angle_max <= pst_pkg::ANGLE_MAX_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        pst_pkg::REG_GAIN_P:    gain_p    <= pwdata[pst_pkg::GAIN_W-1:0];
        pst_pkg::REG_GAIN_I:    gain_i    <= pwdata[pst_pkg::GAIN_W-1:0];
        pst_pkg::REG_GAIN_D:    gain_d    <= pwdata[pst_pkg::GAIN_W-1:0];
        pst_pkg::REG_SETPOINT:  setpoint  <= pwdata[pst_pkg::POS_BITS-1:0];
        pst_pkg::REG_ANGLE_MIN: angle_min <= pwdata[pst_pkg::ANGLE_W-1:0];
        pst_pkg::REG_ANGLE_MAX: angle_max <= pwdata[pst_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // per-stage ready chain
  assign rdy3     = !m_tvalid || m_tready;
  assign rdy2     = !v3 || rdy3;
  assign rdy1     = !v2 || rdy2;
  assign rdy0     = !v1 || rdy1;
  assign s_tready = rdy0;

  // error and saturating integral
  assign pos    = s_tdata[pst_pkg::POS_BITS-1:0];
  assign err_c  = $signed({1'b0, setpoint}) - $signed({1'b0, pos});
  assign sum_wide = (pst_pkg::SUM_W+1)'(error_sum) + (pst_pkg::SUM_W+1)'(err_c);

  always_comb begin
    if (sum_wide > pst_pkg::SUM_MAX) begin
      error_sum_next = pst_pkg::SUM_MAX[pst_pkg::SUM_W-1:0];
    end else if (sum_wide < pst_pkg::SUM_MIN) begin
      error_sum_next = pst_pkg::SUM_MIN[pst_pkg::SUM_W-1:0];
    end else begin
      error_sum_next = sum_wide[pst_pkg::SUM_W-1:0];
    end
  end

  assign derr_c = pst_pkg::DERR_W'(err_c) - pst_pkg::DERR_W'(previous_error);

  // three products summed; the angle term is a whole number so only the
  // integer part of the correction joins it, the fraction only steers rounding
  assign corr_c = pst_pkg::CORR_W'(prod_p) + pst_pkg::CORR_W'(prod_i)
                + pst_pkg::CORR_W'(prod_d);

  assign acc_c = pst_pkg::ACC_W'(angle_now) + pst_pkg::ACC_W'(corr_hi);
  // floor to truncation toward zero
  assign acc_trunc = (acc_c[pst_pkg::ACC_W-1] && frac_nz) ? acc_c + pst_pkg::ACC_W'(1)
                                                         : acc_c;
  assign lim_min = pst_pkg::ACC_W'(angle_min);
  assign lim_max = pst_pkg::ACC_W'(angle_max);

  always_comb begin
    if (acc_trunc < lim_min) begin
      angle_now_next = angle_min;
    end else if (acc_trunc > lim_max) begin
      angle_now_next = angle_max;
    end else begin
      angle_now_next = acc_trunc[pst_pkg::ANGLE_W-1:0];
    end
  end

  // control and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      v1             <= 1'b0;
      v2             <= 1'b0;
      v3             <= 1'b0;
      m_tvalid       <= 1'b0;
      error_sum      <= '0;
      previous_error <= '0;
      angle_now      <= '0;
    end else begin
      if (rdy0) v1 <= s_tvalid;
      if (rdy1) v2 <= v1;
      if (rdy2) v3 <= v2;
      if (rdy3) m_tvalid <= v3;
      if (s_tvalid && rdy0) begin
        error_sum      <= error_sum_next;
        previous_error <= err_c;
      end
      if (v3 && rdy3) angle_now <= angle_now_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rdy0) begin
      err_r  <= err_c;
      sum_r  <= error_sum_next;
      derr_r <= derr_c;
    end
    if (rdy1) begin
      prod_p <= pst_pkg::PROD_P_W'(gain_p) * pst_pkg::PROD_P_W'(err_r);
      prod_i <= pst_pkg::PROD_I_W'(gain_i) * pst_pkg::PROD_I_W'(sum_r);
      prod_d <= pst_pkg::PROD_D_W'(gain_d) * pst_pkg::PROD_D_W'(derr_r);
    end
    if (rdy2) begin
      corr_hi <= corr_c[pst_pkg::CORR_W-1:pst_pkg::FRAC_BITS];
      frac_nz <= |corr_c[pst_pkg::FRAC_BITS-1:0];
    end
  end

  assign m_tdata = pst_pkg::OUT_TDATA_W'(angle_now);

endmodule

`default_nettype wire

// ----- hdl/pst_checker.sv -----
// ----------------------------------------------------------------------------
// pst_checker
// Port-level checks on the servo angle tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             s_tready,
  input wire                             m_tvalid,
  input wire                             m_tready,
  input wire [pst_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input wire [pst_pkg::ADDR_W-1:0]       paddr,
  input wire [pst_pkg::DATA_W-1:0]       prdata
);

  // reset empties the output stage
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // no beat can cross the pipeline faster than its depth after reset
  a_rst_latency: assert property (@(posedge clk) rst |-> ##3 !m_tvalid)
    else $error("result appeared sooner than pipeline latency after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // with the output empty nothing can block the input
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked while output empty");

  // setpoint reads back with no bits above its width
  a_setpoint_rd: assert property (@(posedge clk) disable iff (rst)
    paddr[pst_pkg::ADDR_W-1:2] == pst_pkg::REG_SETPOINT
      |-> prdata[pst_pkg::DATA_W-1:pst_pkg::POS_BITS] == '0)
    else $error("setpoint readback has stray upper bits");

endmodule

bind pid_servo_angle_tracker pst_checker u_pst_checker (.*);

`default_nettype wire
